// ===== src/rds_pkg.sv =====
// Shared types, constants and codes of the reaction-diffusion stencil block.
`default_nettype none
package rds_pkg;
    localparam int COLS_DEF = 128;
    localparam int CELL_W = 64;

    localparam logic signed [31:0] Q_ONE = 32'sd16777216;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef logic [2:0] alu_op_t;
    localparam alu_op_t ALU_NOP  = 3'd0;
    localparam alu_op_t ALU_MUL  = 3'd1;
    localparam alu_op_t ALU_LD   = 3'd2;
    localparam alu_op_t ALU_ADD  = 3'd3;
    localparam alu_op_t ALU_SUB  = 3'd4;
    localparam alu_op_t ALU_SUB4 = 3'd5;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_DIFF_A   = 3'd0;
    localparam reg_idx_t REG_DIFF_B   = 3'd1;
    localparam reg_idx_t REG_SOURCE_P = 3'd2;
    localparam reg_idx_t REG_DECAY_Q  = 3'd3;
    localparam reg_idx_t REG_SAT_R    = 3'd4;
    localparam reg_idx_t REG_TIME_STEP = 3'd5;
    localparam reg_idx_t REG_INV_GRID = 3'd6;

    localparam logic [30:0] RST_DIFF_A = 31'd6710886;
    localparam logic [30:0] RST_DIFF_B = 31'd104018739;
    localparam logic [31:0] RST_SOURCE_P = 32'd0;
    localparam logic [31:0] RST_DECAY_Q = 32'd26843546;
    localparam logic [30:0] RST_SAT_R = 31'd8388608;
    localparam logic [30:0] RST_TIME_STEP = 31'd167772;
    localparam logic [30:0] RST_INV_GRID = 31'd16777216;

    typedef struct packed {
        logic [30:0]        diff_a;
        logic [30:0]        diff_b;
        logic signed [31:0] source_p;
        logic signed [31:0] decay_q;
        logic [30:0]        saturation_r;
        logic [30:0]        time_step;
        logic [30:0]        inv_grid_sq;
    } rds_cfg_t;

    typedef struct packed {
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] na;
        logic signed [31:0] nb;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        logic signed [31:0] ea;
        logic signed [31:0] eb;
    } rds_opnd_t;

    typedef struct packed {
        logic signed [31:0] next_a;
        logic signed [31:0] next_b;
        logic               clipped;
    } rds_res_t;
endpackage
`default_nettype wire

// ===== src/rds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rds_ram #(
    parameter int WIDTH = rds_pkg::CELL_W,
    parameter int DEPTH = 2 * rds_pkg::COLS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/rds_alu.sv =====
// Shared multiply and accumulate unit with Q8.24 rounding and saturation.
`default_nettype none
module rds_alu (
    input  wire logic               aclk,
    input  wire rds_pkg::alu_op_t   op,
    input  wire logic signed [31:0] x,
    input  wire logic signed [31:0] y,
    output logic signed [31:0]      mul_res,
    output logic                    mul_clip,
    output logic signed [31:0]      sat_res,
    output logic                    sat_clip
);
    import rds_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [35:0] acc_reg;
    logic signed [35:0] x_ext;
    logic signed [63:0] rnd;
    logic [8:0]         mul_top;
    logic [4:0]         acc_top;

    assign x_ext = {{4{x[31]}}, x};

    always_ff @(posedge aclk) begin
        case (op)
            ALU_MUL:  prod_reg <= x * y;
            ALU_LD:   acc_reg <= x_ext;
            ALU_ADD:  acc_reg <= acc_reg + x_ext;
            ALU_SUB:  acc_reg <= acc_reg - x_ext;
            ALU_SUB4: acc_reg <= acc_reg - (x_ext <<< 2);
            default: ;
        endcase
    end

    always_comb begin
        rnd = prod_reg + 64'sd8388608;
        mul_top = rnd[63:55];
        mul_clip = !((&mul_top) || !(|mul_top));
        mul_res = mul_clip ? (rnd[63] ? SAT_MIN : SAT_MAX) : rnd[55:24];
        acc_top = acc_reg[35:31];
        sat_clip = !((&acc_top) || !(|acc_top));
        sat_res = sat_clip ? (acc_reg[35] ? SAT_MIN : SAT_MAX) : acc_reg[31:0];
    end
endmodule
`default_nettype wire

// ===== src/rds_div.sv =====
// Radix-4 restoring divider for the Q8.24 quotient with saturation.
`default_nettype none
module rds_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quot,
    output logic                    clip
);
    import rds_pkg::*;

    localparam int STEPS = 28;
    localparam int BITS = 2;
    localparam int NW = 56;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    nsh_reg;
    logic [NW-1:0]    nsh_next;
    logic [31:0]      rem_reg;
    logic [31:0]      rem_next;
    logic [NW-1:0]    q_reg;
    logic [NW-1:0]    q_next;
    logic [31:0]      d_reg;
    logic             neg_reg;
    logic [32:0]      trial;
    logic             over;

    always_comb begin
        rem_next = rem_reg;
        nsh_next = nsh_reg;
        q_next = q_reg;
        trial = '0;
        for (int k = 0; k < BITS; k++) begin
            trial = {rem_next, nsh_next[NW-1]};
            nsh_next = {nsh_next[NW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                trial = trial - {1'b0, d_reg};
                q_next = {q_next[NW-2:0], 1'b1};
            end else begin
                q_next = {q_next[NW-2:0], 1'b0};
            end
            rem_next = trial[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            done_reg <= 1'b0;
            neg_reg <= 1'b0;
            rem_reg <= '0;
            cnt_reg <= '0;
            if (den == 32'sd0) begin
                q_reg <= (num != 32'sd0) ? '1 : '0;
                done_reg <= 1'b1;
                busy_reg <= 1'b0;
            end else begin
                q_reg <= '0;
                neg_reg <= den[31];
                d_reg <= den[31] ? (~den + 32'd1) : den;
                nsh_reg <= {1'b0, num[30:0], 24'd0};
                busy_reg <= 1'b1;
            end
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            nsh_reg <= nsh_next;
            q_reg <= q_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            over = (q_reg[NW-1:32] != '0) || (q_reg[31] && (q_reg[30:0] != '0));
            quot = over ? SAT_MIN : -q_reg[31:0];
        end else begin
            over = (q_reg[NW-1:31] != '0);
            quot = over ? SAT_MAX : q_reg[31:0];
        end
    end

    assign clip = over;
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== src/rds_core.sv =====
// Microcoded sequencer that runs one cell update on the shared unit.
`default_nettype none
module rds_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              res_ready,
    input  wire rds_pkg::rds_cfg_t cfg,
    input  wire rds_pkg::rds_opnd_t opnd,
    output logic                   done,
    output rds_pkg::rds_res_t      res
);
    import rds_pkg::*;

    localparam logic [5:0] U_KA = 6'd0;
    localparam logic [5:0] U_KB = 6'd1;
    localparam logic [5:0] U_A2 = 6'd2;
    localparam logic [5:0] U_RA2 = 6'd3;
    localparam logic [5:0] U_T_LD = 6'd4;
    localparam logic [5:0] U_T_ADD = 6'd5;
    localparam logic [5:0] U_DEN = 6'd6;
    localparam logic [5:0] U_LA_N = 6'd7;
    localparam logic [5:0] U_LA_S = 6'd8;
    localparam logic [5:0] U_LA_W = 6'd9;
    localparam logic [5:0] U_LA_E = 6'd10;
    localparam logic [5:0] U_LA_C = 6'd11;
    localparam logic [5:0] U_LB_N = 6'd12;
    localparam logic [5:0] U_LB_S = 6'd13;
    localparam logic [5:0] U_LB_W = 6'd14;
    localparam logic [5:0] U_LB_E = 6'd15;
    localparam logic [5:0] U_LB_C = 6'd16;
    localparam logic [5:0] U_GA_LD = 6'd17;
    localparam logic [5:0] U_GA_SUB = 6'd18;
    localparam logic [5:0] U_FA_LD = 6'd19;
    localparam logic [5:0] U_FA_MUL = 6'd20;
    localparam logic [5:0] U_FA_SUB = 6'd21;
    localparam logic [5:0] U_FA_DIV = 6'd22;
    localparam logic [5:0] U_DA_MUL = 6'd23;
    localparam logic [5:0] U_DA_LD = 6'd24;
    localparam logic [5:0] U_DA_ADD = 6'd25;
    localparam logic [5:0] U_DB_MUL = 6'd26;
    localparam logic [5:0] U_DB_LD = 6'd27;
    localparam logic [5:0] U_DB_ADD = 6'd28;
    localparam logic [5:0] U_XA_MUL = 6'd29;
    localparam logic [5:0] U_XA_LD = 6'd30;
    localparam logic [5:0] U_XA_ADD = 6'd31;
    localparam logic [5:0] U_XB_MUL = 6'd32;
    localparam logic [5:0] U_XB_LD = 6'd33;
    localparam logic [5:0] U_XB_ADD = 6'd34;
    localparam logic [5:0] U_FIN = 6'd35;

    logic [5:0]         step_reg;
    logic               busy_reg;
    logic               clip_reg;
    logic               clip_next;
    logic signed [31:0] ka_reg, kb_reg, a2_reg, la_reg, lb_reg;
    logic signed [31:0] ga_reg, fa_reg, da_reg, db_reg, xa_reg;

    alu_op_t            op;
    logic signed [31:0] x, y;
    logic signed [31:0] mul_res, sat_res, div_quot;
    logic               mul_clip, sat_clip, div_clip, div_done;
    logic               take_mr, take_sr, take_dv, div_go, advance;

    rds_alu u_alu (
        .aclk     (aclk),
        .op       (op),
        .x        (x),
        .y        (y),
        .mul_res  (mul_res),
        .mul_clip (mul_clip),
        .sat_res  (sat_res),
        .sat_clip (sat_clip)
    );

    rds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .num     (a2_reg),
        .den     (mul_res),
        .done    (div_done),
        .quot    (div_quot),
        .clip    (div_clip)
    );

    always_comb begin
        op = ALU_NOP;
        x = '0;
        y = '0;
        take_mr = 1'b0;
        take_sr = 1'b0;
        take_dv = 1'b0;
        div_go = 1'b0;
        if (busy_reg) begin
            case (step_reg)
                U_KA: begin
                    op = ALU_MUL; x = {1'b0, cfg.diff_a}; y = {1'b0, cfg.inv_grid_sq};
                end
                U_KB: begin
                    op = ALU_MUL; x = {1'b0, cfg.diff_b}; y = {1'b0, cfg.inv_grid_sq};
                    take_mr = 1'b1;
                end
                U_A2: begin
                    op = ALU_MUL; x = opnd.ca; y = opnd.ca; take_mr = 1'b1;
                end
                U_RA2: begin
                    op = ALU_MUL; x = {1'b0, cfg.saturation_r}; y = mul_res; take_mr = 1'b1;
                end
                U_T_LD: begin
                    op = ALU_LD; x = Q_ONE;
                end
                U_T_ADD: begin
                    op = ALU_ADD; x = mul_res; take_mr = 1'b1;
                end
                U_DEN: begin
                    op = ALU_MUL; x = opnd.cb; y = sat_res; take_sr = 1'b1;
                end
                U_LA_N: begin
                    op = ALU_LD; x = opnd.na; take_mr = 1'b1; div_go = 1'b1;
                end
                U_LA_S: begin op = ALU_ADD; x = opnd.sa; end
                U_LA_W: begin op = ALU_ADD; x = opnd.wa; end
                U_LA_E: begin op = ALU_ADD; x = opnd.ea; end
                U_LA_C: begin op = ALU_SUB4; x = opnd.ca; end
                U_LB_N: begin op = ALU_LD; x = opnd.nb; take_sr = 1'b1; end
                U_LB_S: begin op = ALU_ADD; x = opnd.sb; end
                U_LB_W: begin op = ALU_ADD; x = opnd.wb; end
                U_LB_E: begin op = ALU_ADD; x = opnd.eb; end
                U_LB_C: begin op = ALU_SUB4; x = opnd.cb; end
                U_GA_LD: begin op = ALU_LD; x = a2_reg; take_sr = 1'b1; end
                U_GA_SUB: begin op = ALU_SUB; x = opnd.cb; end
                U_FA_LD: begin op = ALU_LD; x = cfg.source_p; take_sr = 1'b1; end
                U_FA_MUL: begin op = ALU_MUL; x = cfg.decay_q; y = opnd.ca; end
                U_FA_SUB: begin op = ALU_SUB; x = mul_res; take_mr = 1'b1; end
                U_FA_DIV: begin
                    if (div_done) begin
                        op = ALU_ADD; x = div_quot; take_dv = 1'b1;
                    end
                end
                U_DA_MUL: begin
                    op = ALU_MUL; x = ka_reg; y = la_reg; take_sr = 1'b1;
                end
                U_DA_LD: begin op = ALU_LD; x = mul_res; take_mr = 1'b1; end
                U_DA_ADD: begin op = ALU_ADD; x = fa_reg; end
                U_DB_MUL: begin
                    op = ALU_MUL; x = kb_reg; y = lb_reg; take_sr = 1'b1;
                end
                U_DB_LD: begin op = ALU_LD; x = mul_res; take_mr = 1'b1; end
                U_DB_ADD: begin op = ALU_ADD; x = ga_reg; end
                U_XA_MUL: begin
                    op = ALU_MUL; x = da_reg; y = {1'b0, cfg.time_step}; take_sr = 1'b1;
                end
                U_XA_LD: begin op = ALU_LD; x = opnd.ca; end
                U_XA_ADD: begin op = ALU_ADD; x = mul_res; take_mr = 1'b1; end
                U_XB_MUL: begin
                    op = ALU_MUL; x = db_reg; y = {1'b0, cfg.time_step}; take_sr = 1'b1;
                end
                U_XB_LD: begin op = ALU_LD; x = opnd.cb; end
                U_XB_ADD: begin op = ALU_ADD; x = mul_res; take_mr = 1'b1; end
                default: ;
            endcase
        end
    end

    assign advance = busy_reg && !((step_reg == U_FA_DIV) && !div_done)
                     && !((step_reg == U_FIN) && !res_ready);
    assign clip_next = clip_reg | (take_mr & mul_clip) | (take_sr & sat_clip)
                       | (take_dv & div_clip);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= U_KA;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= U_KA;
        end else if (advance) begin
            if (step_reg == U_FIN) begin
                busy_reg <= 1'b0;
            end else begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            clip_reg <= 1'b0;
        end else if (advance) begin
            clip_reg <= clip_next;
            case (step_reg)
                U_KB:     ka_reg <= mul_res;
                U_A2:     kb_reg <= mul_res;
                U_RA2:    a2_reg <= mul_res;
                U_LB_N:   la_reg <= sat_res;
                U_GA_LD:  lb_reg <= sat_res;
                U_FA_LD:  ga_reg <= sat_res;
                U_DA_MUL: fa_reg <= sat_res;
                U_DB_MUL: da_reg <= sat_res;
                U_XA_MUL: db_reg <= sat_res;
                U_XB_MUL: xa_reg <= sat_res;
                default: ;
            endcase
        end
    end

    assign done = busy_reg && (step_reg == U_FIN);
    assign res.next_a = xa_reg;
    assign res.next_b = sat_res;
    assign res.clipped = clip_reg | sat_clip;
endmodule
`default_nettype wire

// ===== src/reaction_diffusion_stencil_step.sv =====
// Top level of the reaction-diffusion Euler step block.
// Cells enter in raster order, COLS per row; results come one row late and drain
// items flush the last row. A data item of the first row is only written to the
// row store; any other item reads its neighbours from the row store on the single
// read port, then runs a 36-step microcode on the shared multiply/accumulate unit,
// which waits for the 28-iteration radix-4 divider of the reaction quotient. No
// clearing pass follows reset; the block is ready at once.
`default_nettype none
module reaction_diffusion_stencil_step #(
    parameter int COLS = rds_pkg::COLS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // conc_a[31:0], conc_b[63:32]
    input  wire logic        s_tuser,   // drain
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // next_a[31:0], next_b[63:32]
    output logic             m_tuser,   // clipped
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rds_pkg::*;

    localparam int CW = $clog2(COLS);
    localparam int AW = CW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]         state_reg;
    logic [2:0]         rd_reg;
    logic [CW-1:0]      col_reg;
    logic [1:0]         rows_reg;
    logic               slot_reg;
    logic signed [31:0] in_a_reg, in_b_reg;
    logic               drain_reg;
    rds_opnd_t          opnd_reg;
    rds_cfg_t           cfg_reg;
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic               m_clip_reg;
    logic               m_last_reg;

    logic [CW-1:0]      col_w, col_e;
    logic               last_col;
    logic [AW-1:0]      raddr;
    logic [63:0]        rdata;
    logic               we;
    logic               core_start, core_done, res_ready;
    rds_res_t           core_res;
    logic               in_xfer, cfg_wr;

    assign last_col = (col_reg == CW'(COLS - 1));
    assign col_w = (col_reg == '0) ? CW'(COLS - 1) : col_reg - 1'b1;
    assign col_e = last_col ? '0 : col_reg + 1'b1;

    always_comb begin
        case (rd_reg)
            3'd0:    raddr = {slot_reg, col_reg};
            3'd1:    raddr = {~slot_reg, col_reg};
            3'd2:    raddr = {slot_reg, col_w};
            default: raddr = {slot_reg, col_e};
        endcase
    end

    assign we = (state_reg == ST_WRITE) && !drain_reg;

    rds_ram #(
        .WIDTH (CELL_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr ({~slot_reg, col_reg}),
        .wdata ({in_b_reg, in_a_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign core_start = (state_reg == ST_READ) && (rd_reg == 3'd4);
    assign res_ready = !m_valid_reg || m_tready;

    rds_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (core_start),
        .res_ready (res_ready),
        .cfg       (cfg_reg),
        .opnd      (opnd_reg),
        .done      (core_done),
        .res       (core_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rd_reg <= '0;
            col_reg <= '0;
            rows_reg <= '0;
            slot_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        in_a_reg <= s_tdata[31:0];
                        in_b_reg <= s_tdata[63:32];
                        drain_reg <= s_tuser;
                        rd_reg <= '0;
                        if (rows_reg != 2'd0) begin
                            state_reg <= ST_READ;
                        end else if (!s_tuser) begin
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_READ: begin
                    rd_reg <= rd_reg + 1'b1;
                    case (rd_reg)
                        3'd1: begin
                            opnd_reg.ca <= rdata[31:0];
                            opnd_reg.cb <= rdata[63:32];
                            opnd_reg.sa <= drain_reg ? rdata[31:0] : in_a_reg;
                            opnd_reg.sb <= drain_reg ? rdata[63:32] : in_b_reg;
                        end
                        3'd2: begin
                            opnd_reg.na <= rows_reg[1] ? rdata[31:0] : opnd_reg.ca;
                            opnd_reg.nb <= rows_reg[1] ? rdata[63:32] : opnd_reg.cb;
                        end
                        3'd3: begin
                            opnd_reg.wa <= rdata[31:0];
                            opnd_reg.wb <= rdata[63:32];
                        end
                        3'd4: begin
                            opnd_reg.ea <= rdata[31:0];
                            opnd_reg.eb <= rdata[63:32];
                            state_reg <= ST_CALC;
                        end
                        default: ;
                    endcase
                end
                ST_CALC: begin
                    if (core_done && res_ready) begin
                        state_reg <= ST_WRITE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    if (last_col) begin
                        col_reg <= '0;
                        if (drain_reg) begin
                            rows_reg <= '0;
                        end else begin
                            slot_reg <= ~slot_reg;
                            if (!rows_reg[1]) begin
                                rows_reg <= rows_reg + 1'b1;
                            end
                        end
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_CALC) && core_done && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_CALC) && core_done && res_ready) begin
            m_data_reg <= {core_res.next_b, core_res.next_a};
            m_clip_reg <= core_res.clipped;
            m_last_reg <= drain_reg && last_col;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_clip_reg;
    assign m_tlast = m_last_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.diff_a <= RST_DIFF_A;
            cfg_reg.diff_b <= RST_DIFF_B;
            cfg_reg.source_p <= RST_SOURCE_P;
            cfg_reg.decay_q <= RST_DECAY_Q;
            cfg_reg.saturation_r <= RST_SAT_R;
            cfg_reg.time_step <= RST_TIME_STEP;
            cfg_reg.inv_grid_sq <= RST_INV_GRID;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_DIFF_A:    cfg_reg.diff_a <= pwdata[30:0];
                REG_DIFF_B:    cfg_reg.diff_b <= pwdata[30:0];
                REG_SOURCE_P:  cfg_reg.source_p <= pwdata;
                REG_DECAY_Q:   cfg_reg.decay_q <= pwdata;
                REG_SAT_R:     cfg_reg.saturation_r <= pwdata[30:0];
                REG_TIME_STEP: cfg_reg.time_step <= pwdata[30:0];
                REG_INV_GRID:  cfg_reg.inv_grid_sq <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DIFF_A:    prdata = {1'b0, cfg_reg.diff_a};
            REG_DIFF_B:    prdata = {1'b0, cfg_reg.diff_b};
            REG_SOURCE_P:  prdata = cfg_reg.source_p;
            REG_DECAY_Q:   prdata = cfg_reg.decay_q;
            REG_SAT_R:     prdata = {1'b0, cfg_reg.saturation_r};
            REG_TIME_STEP: prdata = {1'b0, cfg_reg.time_step};
            REG_INV_GRID:  prdata = {1'b0, cfg_reg.inv_grid_sq};
            default:       prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/rds_checker.sv =====
// Port-level checker for the reaction-diffusion block, bound to the top level.
`default_nettype none
module rds_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    a_busy_after_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser) |=> !s_tready)
        else $error("ready stayed high after a cell transfer");

    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                     && $stable(m_tuser)))
        else $error("stalled result changed");
endmodule

bind reaction_diffusion_stencil_step rds_checker u_rds_checker (.*);
`default_nettype wire
